// ----- rtl/uktc_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uktc_pkg
// Shared types and constants for the unique key table with compaction.
// ---------------------------------------------------------------------------
package uktc_pkg;

   localparam int DEPTH         = 64;
   localparam int KEY_BITS      = 64;
   localparam int COUNT_BITS    = $clog2(DEPTH + 1);
   localparam int PREFIX_LEVELS = $clog2(DEPTH);

   localparam int OP_W     = 2;
   localparam int KEY_W    = 64;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;

   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef enum logic [OP_W-1:0] {
      OP_CREATE = 2'd0,
      OP_DELETE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_LIST   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_CREATED   = 3'd0,
      STS_EXISTS    = 3'd1,
      STS_FULL      = 3'd2,
      STS_DELETED   = 3'd3,
      STS_NOT_FOUND = 3'd4,
      STS_FOUND     = 3'd5,
      STS_EMPTY     = 3'd6,
      STS_LIST      = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      CELL_IDLE,
      CELL_MATCH,
      CELL_WRITE,
      CELL_SHIFT,
      CELL_ROTATE
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      key_type      key;
      count_type    count;
   } cell_ctrl_type;

endpackage

// ----- rtl/uktc_channels.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uktc channels
// Valid/ready channel interfaces for requests and responses.
// ---------------------------------------------------------------------------
interface uktc_req_if;
   import uktc_pkg::*;

   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  operation;
   logic [KEY_W-1:0] key;

   modport source (output valid, output operation, output key, input ready);
   modport sink   (input valid, input operation, input key, output ready);
endinterface

interface uktc_rsp_if;
   import uktc_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [KEY_W-1:0]    entry_key;
   logic [COUNT_W-1:0]  entry_count;
   logic                last;

   modport source (output valid, output status, output entry_key, output entry_count,
                   output last, input ready);
   modport sink   (input valid, input status, input entry_key, input entry_count,
                   input last, output ready);
endinterface

// ----- rtl/unique_key_table_with_compaction.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// unique_key_table_with_compaction
// Ordered table of unique keys: create, delete with compaction, search, list.
//
//   channel  dir  payload                                   transfer
//   req_if   in   operation, key                            valid & ready
//   rsp_if   out  status, entry_key, entry_count, last      valid & ready
//
// Create, delete and search run a parallel compare in every cell, then the
// decision with an append or a one-step shift of the later cells.
// List rotates the ring of cells DEPTH times, one slot a cycle while no
// response is stalled, and emits the head cell while the rotation is below
// the count, after the compare and the decision.
// A stalled response holds the decision or the rotation; requests are taken
// only between operations. Reset clears the count; cell keys are not reset.
// ---------------------------------------------------------------------------
module unique_key_table_with_compaction (
   input  logic       clock,
   input  logic       reset,
   uktc_req_if.sink   req_if,
   uktc_rsp_if.source rsp_if
);
   import uktc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_LIST
   } state_type;

   state_type     state_ff,  state_in;
   op_type        op_ff,     op_in;
   key_type       key_ff,    key_in;
   count_type     count_ff,  count_in;
   count_type     rot_ff,    rot_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    status_ff, status_in;
   key_type       rkey_ff,   rkey_in;
   count_type     rcount_ff, rcount_in;
   logic          last_ff,   last_in;

   cell_ctrl_type ctrl;
   key_type       head_key;
   logic          any_hit;
   logic          accept;
   logic          slot_free;
   logic          list_emit;
   logic          advance;

   uktc_chain u_chain (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .head_key (head_key),
      .any_hit  (any_hit)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign slot_free    = !rsp_valid_ff || rsp_if.ready;
   assign list_emit    = (rot_ff < count_ff);
   assign advance      = !list_emit || slot_free;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      rot_in       = rot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      status_in    = status_ff;
      rkey_in      = rkey_ff;
      rcount_in    = rcount_ff;
      last_in      = last_ff;

      ctrl.cmd   = CELL_IDLE;
      ctrl.key   = (state_ff == ST_IDLE) ? KEY_BITS'(req_if.key) : key_ff;
      ctrl.count = count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctrl.cmd = CELL_MATCH;
               op_in    = op_type'(req_if.operation);
               key_in   = KEY_BITS'(req_if.key);
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (slot_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rkey_in      = key_ff;
               last_in      = 1'b1;
               unique case (op_ff)
                  OP_CREATE: begin
                     if (count_ff == COUNT_BITS'(DEPTH)) begin
                        status_in = STS_FULL;
                     end else if (any_hit) begin
                        status_in = STS_EXISTS;
                     end else begin
                        ctrl.cmd  = CELL_WRITE;
                        count_in  = count_type'(count_ff + 1'b1);
                        status_in = STS_CREATED;
                     end
                  end
                  OP_DELETE: begin
                     if (any_hit) begin
                        ctrl.cmd  = CELL_SHIFT;
                        count_in  = count_type'(count_ff - 1'b1);
                        status_in = STS_DELETED;
                     end else begin
                        status_in = STS_NOT_FOUND;
                     end
                  end
                  OP_SEARCH: begin
                     status_in = any_hit ? STS_FOUND : STS_NOT_FOUND;
                  end
                  default: begin
                     if (count_ff == '0) begin
                        status_in = STS_EMPTY;
                        rkey_in   = '0;
                     end else begin
                        rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
                        rot_in       = '0;
                        state_in     = ST_LIST;
                     end
                  end
               endcase
               rcount_in = count_in;
            end
         end
         ST_LIST: begin
            if (advance) begin
               ctrl.cmd = CELL_ROTATE;
               rot_in   = count_type'(rot_ff + 1'b1);
               if (list_emit) begin
                  rsp_valid_in = 1'b1;
                  status_in    = STS_LIST;
                  rkey_in      = head_key;
                  rcount_in    = count_ff;
                  last_in      = (rot_ff == count_type'(count_ff - 1'b1));
               end
               if (rot_ff == COUNT_BITS'(DEPTH - 1)) begin
                  rot_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rot_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rot_ff       <= rot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      rkey_ff   <= rkey_in;
      rcount_ff <= rcount_in;
      last_ff   <= last_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = status_ff;
   assign rsp_if.entry_key   = KEY_W'(rkey_ff);
   assign rsp_if.entry_count = COUNT_W'(rcount_ff);
   assign rsp_if.last        = last_ff;

endmodule

// ----- rtl/uktc_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uktc_cell
// One table slot: holds a key, compares it, loads it or takes its neighbour's.
// ---------------------------------------------------------------------------
module uktc_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  uktc_pkg::cell_ctrl_type ctrl,
   input  uktc_pkg::count_type     idx,
   input  logic                    shift_en,
   input  uktc_pkg::key_type       next_key,
   output uktc_pkg::key_type       data_out,
   output logic                    hit_out
);
   import uktc_pkg::*;

   key_type data_ff;
   key_type data_in;
   logic    hit_ff;
   logic    hit_in;

   always_comb begin
      data_in = data_ff;
      hit_in  = hit_ff;
      unique case (ctrl.cmd)
         CELL_MATCH: begin
            hit_in = (data_ff == ctrl.key) && (idx < ctrl.count);
         end
         CELL_WRITE: begin
            if (idx == ctrl.count) begin
               data_in = ctrl.key;
            end
         end
         CELL_SHIFT: begin
            if (shift_en) begin
               data_in = next_key;
            end
         end
         CELL_ROTATE: begin
            data_in = next_key;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign hit_out  = hit_ff;

endmodule

// ----- rtl/uktc_chain.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uktc_chain
// Row of table cells, wrapped into a ring, with the match prefix for deletes.
// ---------------------------------------------------------------------------
module uktc_chain (
   input  logic                    clock,
   input  logic                    reset,
   input  uktc_pkg::cell_ctrl_type ctrl,
   output uktc_pkg::key_type       head_key,
   output logic                    any_hit
);
   import uktc_pkg::*;

   key_type          cell_key [DEPTH];
   logic [DEPTH-1:0] hit_vec;
   logic [DEPTH-1:0] prefix [PREFIX_LEVELS+1];

   // cells at or above the matching slot take their neighbour's key
   always_comb begin
      prefix[0] = hit_vec;
      for (int l = 0; l < PREFIX_LEVELS; l++) begin
         prefix[l+1] = prefix[l] | (prefix[l] << (1 << l));
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      uktc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .idx      (COUNT_BITS'(g)),
         .shift_en (prefix[PREFIX_LEVELS][g]),
         .next_key (cell_key[(g + 1) % DEPTH]),
         .data_out (cell_key[g]),
         .hit_out  (hit_vec[g])
      );
   end

   assign head_key = cell_key[0];
   assign any_hit  = |hit_vec;

endmodule

// ----- dv/unique_key_table_with_compaction_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// unique_key_table_with_compaction_tb
// Self-checking bench for the unique key table. A short scripted sequence
// covers the empty table, extreme keys, duplicates, misses and deletes at
// the head, middle and tail. It is followed by random traffic that fills the
// table to capacity, drains it and churns it. Every response transfer is
// checked field by field against a queue-based model of the table. The
// request side sends in bursts; the response side stalls in windows and once
// for a long stretch, so the block backs up.
// ---------------------------------------------------------------------------
module unique_key_table_with_compaction_tb;
   import uktc_pkg::*;

   localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} :
                                           ((64'd1 << KEY_BITS) - 64'd1);
   localparam int RANDOM_ITEMS = 451;
   localparam int SCRIPT_LEN   = 19;

   typedef struct packed {
      status_type         status;
      logic [KEY_W-1:0]   entry_key;
      logic [COUNT_W-1:0] entry_count;
      logic               last;
   } rsp_beat_type;

   typedef struct packed {
      op_type             op;
      logic [KEY_W-1:0]   key;
      logic               typed;
      status_type         status;
      logic [COUNT_W-1:0] count;
   } script_row_type;

   typedef enum logic [1:0] {
      PH_GROW,
      PH_SHRINK,
      PH_CHURN
   } traffic_phase_type;

   logic clock;
   logic reset;

   uktc_req_if req_if ();
   uktc_rsp_if rsp_if ();

   unique_key_table_with_compaction DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   logic [KEY_W-1:0] stored_keys[$];
   rsp_beat_type     owed_rsp[$];
   script_row_type   script[SCRIPT_LEN];

   int error_count;
   int sent_count;
   int list_count;
   int checked_count;
   int peak_fill;
   int status_seen[8];
   int burst_left;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic logic [KEY_W-1:0] fresh_key();
      return {$urandom, $urandom};
   endfunction

   // present key with the given chance, otherwise a random one
   function automatic logic [KEY_W-1:0] pick_key(int pct);
      if (stored_keys.size() > 0 && $urandom_range(0, 99) < pct)
         return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      return fresh_key();
   endfunction

   function automatic void owe(status_type st, logic [KEY_W-1:0] k, int n, logic lst);
      rsp_beat_type b;
      b.status      = st;
      b.entry_key   = k;
      b.entry_count = COUNT_W'(n);
      b.last        = lst;
      owed_rsp.push_back(b);
   endfunction

   function automatic void apply_table_op(op_type op, logic [KEY_W-1:0] raw);
      logic [KEY_W-1:0] k;
      int pos;
      k   = raw & KEY_MASK;
      pos = -1;
      foreach (stored_keys[i])
         if (pos < 0 && stored_keys[i] == k)
            pos = i;
      case (op)
         OP_CREATE: begin
            if (stored_keys.size() >= DEPTH) begin
               owe(STS_FULL, k, stored_keys.size(), 1'b1);
            end else if (pos >= 0) begin
               owe(STS_EXISTS, k, stored_keys.size(), 1'b1);
            end else begin
               stored_keys.push_back(k);
               owe(STS_CREATED, k, stored_keys.size(), 1'b1);
            end
         end
         OP_DELETE: begin
            if (pos < 0) begin
               owe(STS_NOT_FOUND, k, stored_keys.size(), 1'b1);
            end else begin
               stored_keys.delete(pos);
               owe(STS_DELETED, k, stored_keys.size(), 1'b1);
            end
         end
         OP_SEARCH: begin
            owe((pos >= 0) ? STS_FOUND : STS_NOT_FOUND, k, stored_keys.size(), 1'b1);
         end
         default: begin
            list_count++;
            if (stored_keys.size() == 0)
               owe(STS_EMPTY, '0, 0, 1'b1);
            foreach (stored_keys[j])
               owe(STS_LIST, stored_keys[j], stored_keys.size(),
                   j == stored_keys.size() - 1);
         end
      endcase
      if (stored_keys.size() > peak_fill)
         peak_fill = stored_keys.size();
   endfunction

   task automatic send_req(op_type op, logic [KEY_W-1:0] k);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_if.valid     <= 1'b1;
      req_if.operation <= op;
      req_if.key       <= k;
      do
         @(posedge clock);
      while (!req_if.ready);
      sent_count++;
   endtask

   function automatic void check_field(string name, logic [KEY_W-1:0] exp,
                                       logic [KEY_W-1:0] act);
      if (act !== exp) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp, act);
         error_count++;
      end
   endfunction

   // response monitor
   always @(posedge clock) begin
      rsp_beat_type exp;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         checked_count++;
         status_seen[rsp_if.status]++;
         if (owed_rsp.size() == 0) begin
            $error("unexpected response transfer: status %0d key 0x%0h",
                   rsp_if.status, rsp_if.entry_key);
            error_count++;
         end else begin
            exp = owed_rsp.pop_front();
            check_field("status", exp.status, rsp_if.status);
            check_field("entry_key", exp.entry_key, rsp_if.entry_key);
            check_field("entry_count", exp.entry_count, rsp_if.entry_count);
            check_field("last", exp.last, rsp_if.last);
         end
      end
   end

   // response side back-pressure, with one long hold-off
   initial begin
      int window;
      int mode;
      int hold_left;
      int seen;
      bit held;
      window    = 0;
      mode      = 0;
      hold_left = 0;
      seen      = 0;
      held      = 1'b0;
      rsp_if.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            seen++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (!held && seen >= 150) begin
            held      = 1'b1;
            hold_left = 400;
            rsp_if.ready <= 1'b0;
         end else begin
            if (window == 0) begin
               mode   = $urandom_range(0, 3);
               window = $urandom_range(20, 80);
            end
            window--;
            case (mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_if.ready <= (window % 3 == 0);
            endcase
         end
      end
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int owed_mark;
      int r;
      int full_hits;
      int empty_hits;
      int churn_left;
      op_type op;
      logic [KEY_W-1:0] k;
      traffic_phase_type phase;

      error_count   = 0;
      sent_count    = 0;
      list_count    = 0;
      checked_count = 0;
      peak_fill     = 0;
      burst_left    = 0;
      full_hits     = 0;
      empty_hits    = 0;
      churn_left    = 0;
      phase         = PH_GROW;
      foreach (status_seen[i])
         status_seen[i] = 0;

      script = '{
         '{OP_LIST,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, STS_EMPTY,     7'd0},
         '{OP_SEARCH, 64'h0000_0000_0000_0000, 1'b1, STS_NOT_FOUND, 7'd0},
         '{OP_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, STS_NOT_FOUND, 7'd0},
         '{OP_CREATE, 64'h0000_0000_0000_0000, 1'b1, STS_CREATED,   7'd1},
         '{OP_CREATE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, STS_CREATED,   7'd2},
         '{OP_CREATE, 64'h0000_0000_0000_0000, 1'b1, STS_EXISTS,    7'd2},
         '{OP_CREATE, 64'h8000_0000_0000_0000, 1'b0, STS_CREATED,   7'd0},
         '{OP_CREATE, 64'h0123_4567_89AB_CDEF, 1'b0, STS_CREATED,   7'd0},
         '{OP_CREATE, 64'h0000_0000_0000_0001, 1'b0, STS_CREATED,   7'd0},
         '{OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, STS_CREATED,   7'd0},
         '{OP_LIST,   64'h0000_0000_0000_0000, 1'b0, STS_CREATED,   7'd0},
         '{OP_DELETE, 64'h0000_0000_0000_0000, 1'b0, STS_CREATED,   7'd0},
         '{OP_DELETE, 64'h0123_4567_89AB_CDEF, 1'b0, STS_CREATED,   7'd0},
         '{OP_DELETE, 64'h0123_4567_89AB_CDEF, 1'b1, STS_NOT_FOUND, 7'd3},
         '{OP_SEARCH, 64'h0000_0000_0000_0000, 1'b1, STS_NOT_FOUND, 7'd3},
         '{OP_DELETE, 64'h0000_0000_0000_0001, 1'b0, STS_CREATED,   7'd0},
         '{OP_LIST,   64'h5555_5555_5555_5555, 1'b0, STS_CREATED,   7'd0},
         '{OP_CREATE, 64'h0000_0000_0000_0000, 1'b0, STS_CREATED,   7'd0},
         '{OP_LIST,   64'hAAAA_AAAA_AAAA_AAAA, 1'b0, STS_CREATED,   7'd0}
      };

      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.operation <= OP_CREATE;
      req_if.key       <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         send_req(script[i].op, script[i].key);
         owed_mark = owed_rsp.size();
         apply_table_op(script[i].op, script[i].key);
         if (script[i].typed) begin
            while (owed_rsp.size() > owed_mark)
               void'(owed_rsp.pop_back());
            owe(script[i].status,
                (script[i].op == OP_LIST) ? '0 : (script[i].key & KEY_MASK),
                script[i].count, 1'b1);
         end
      end

      // grow to capacity, drain to empty, churn, repeat
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         r = $urandom_range(0, 99);
         case (phase)
            PH_GROW:
               op = (r < 75) ? OP_CREATE : (r < 85) ? OP_SEARCH :
                    (r < 93) ? OP_DELETE : OP_LIST;
            PH_SHRINK:
               op = (r < 70) ? OP_DELETE : (r < 80) ? OP_CREATE :
                    (r < 94) ? OP_SEARCH : OP_LIST;
            default:
               op = (r < 30) ? OP_CREATE : (r < 60) ? OP_DELETE :
                    (r < 90) ? OP_SEARCH : OP_LIST;
         endcase
         case (op)
            OP_CREATE: k = pick_key(20);
            OP_LIST:   k = fresh_key();
            default:   k = pick_key(80);
         endcase
         send_req(op, k);
         apply_table_op(op, k);

         case (phase)
            PH_GROW: begin
               if (stored_keys.size() == DEPTH && op == OP_CREATE)
                  full_hits++;
               if (full_hits >= 8)
                  phase = PH_SHRINK;
            end
            PH_SHRINK: begin
               if (stored_keys.size() == 0)
                  empty_hits++;
               if (empty_hits >= 4) begin
                  phase      = PH_CHURN;
                  churn_left = $urandom_range(40, 80);
               end
            end
            default: begin
               churn_left--;
               if (churn_left <= 0) begin
                  phase      = PH_GROW;
                  full_hits  = 0;
                  empty_hits = 0;
               end
            end
         endcase
      end

      req_if.valid <= 1'b0;
      while (owed_rsp.size() != 0)
         @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);

      $display("Sent %0d requests (%0d lists), checked %0d response transfers, peak fill %0d/%0d.",
               sent_count, list_count, checked_count, peak_fill, DEPTH);
      $display("Statuses: created %0d exists %0d full %0d deleted %0d missing %0d found %0d empty %0d entry %0d.",
               status_seen[STS_CREATED], status_seen[STS_EXISTS], status_seen[STS_FULL],
               status_seen[STS_DELETED], status_seen[STS_NOT_FOUND], status_seen[STS_FOUND],
               status_seen[STS_EMPTY], status_seen[STS_LIST]);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/uktc_pkg.sv
rtl/uktc_channels.sv
rtl/uktc_cell.sv
rtl/uktc_chain.sv
rtl/unique_key_table_with_compaction.sv
dv/unique_key_table_with_compaction_tb.sv
